// File: src/ppi_pkg.sv
// Shared types, widths and preset palette for the pixel palette indexer.
package ppi_pkg;

	localparam int CHAN_W       = 8;
	localparam int COLOR_W      = 15;
	localparam int INDEX_W      = 8;
	localparam int PRESET_IDX_W = 4;

	localparam int DEFAULT_PALETTE_ENTRIES = 256;
	localparam int DEFAULT_PRESET_ENTRIES  = 16;

	// Item handed from the front to the back through the queue
	typedef struct packed {
		logic [COLOR_W-1:0]      color;
		logic                    sof;
		logic                    preset_hit;
		logic [PRESET_IDX_W-1:0] preset_idx;
	} item_t;

	// CGA colors in BGR555, entry 0 is black
	function automatic logic [COLOR_W-1:0] cga_color(input logic [PRESET_IDX_W-1:0] k);
		logic [COLOR_W-1:0] c;
		unique case (k)
			4'd0:  c = 15'h0000;
			4'd1:  c = 15'h5400;
			4'd2:  c = 15'h02a0;
			4'd3:  c = 15'h56a0;
			4'd4:  c = 15'h0015;
			4'd5:  c = 15'h5415;
			4'd6:  c = 15'h0155;
			4'd7:  c = 15'h56b5;
			4'd8:  c = 15'h294a;
			4'd9:  c = 15'h7d4a;
			4'd10: c = 15'h2bea;
			4'd11: c = 15'h7fea;
			4'd12: c = 15'h295f;
			4'd13: c = 15'h7d5f;
			4'd14: c = 15'h2bff;
			4'd15: c = 15'h7fff;
		endcase
		return c;
	endfunction

	// Keep the top nibble and repeat its top bit below it
	function automatic logic [4:0] widen_channel(input logic [CHAN_W-1:0] byte_in);
		return {byte_in[7:4], byte_in[7]};
	endfunction

endpackage

// File: src/pixel_palette_indexer.sv
// Top level of the pixel palette indexer.
// Each pixel is packed to BGR555 and mapped to a palette index. Black, a
// preset color, any pixel after overflow, and a new color while nothing has
// been appended yet finish without a scan in the back end. Otherwise the back
// end reads the appended entries one per cycle from its palette memory, until
// it finds a match or passes the last appended entry. A two-entry queue lets
// the input keep accepting while a lookup runs, and the output register holds
// a result until it is taken. No clearing pass is needed after reset.
module pixel_palette_indexer #(
	parameter int PALETTE_ENTRIES = ppi_pkg::DEFAULT_PALETTE_ENTRIES,
	parameter int PRESET_ENTRIES  = ppi_pkg::DEFAULT_PRESET_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ppi_pkg::CHAN_W-1:0]  red,
	input  logic [ppi_pkg::CHAN_W-1:0]  green,
	input  logic [ppi_pkg::CHAN_W-1:0]  blue,
	input  logic                        start_of_image,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppi_pkg::INDEX_W-1:0] palette_index,
	output logic [ppi_pkg::COLOR_W-1:0] packed_color,
	output logic                        non_preset_color,
	output logic                        palette_overflow
);
	import ppi_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	ppi_front #(
		.PRESET_ENTRIES(PRESET_ENTRIES)
	) u_front (
		.red           (red),
		.green         (green),
		.blue          (blue),
		.start_of_image(start_of_image),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	ppi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	ppi_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.PRESET_ENTRIES (PRESET_ENTRIES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.palette_index   (palette_index),
		.packed_color    (packed_color),
		.non_preset_color(non_preset_color),
		.palette_overflow(palette_overflow)
	);

endmodule

// File: src/ppi_front.sv
// Front end: packs the pixel as BGR555 and matches it against the presets.
module ppi_front #(
	parameter int PRESET_ENTRIES = ppi_pkg::DEFAULT_PRESET_ENTRIES
) (
	input  logic [ppi_pkg::CHAN_W-1:0] red,
	input  logic [ppi_pkg::CHAN_W-1:0] green,
	input  logic [ppi_pkg::CHAN_W-1:0] blue,
	input  logic                       start_of_image,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       push_valid,
	input  logic                       push_ready,
	output ppi_pkg::item_t             push_item
);
	import ppi_pkg::*;

	logic [COLOR_W-1:0]      color;
	logic                    hit;
	logic [PRESET_IDX_W-1:0] hit_idx;

	assign color = {widen_channel(blue), widen_channel(green), widen_channel(red)};

	// Lowest preset entry above black that holds this color
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = PRESET_ENTRIES - 1; k >= 1; k--) begin
			if (color == cga_color(PRESET_IDX_W'(k))) begin
				hit     = 1'b1;
				hit_idx = PRESET_IDX_W'(k);
			end
		end
	end

	assign push_item.color      = color;
	assign push_item.sof        = start_of_image;
	assign push_item.preset_hit = hit;
	assign push_item.preset_idx = hit_idx;
	assign push_valid           = in_valid;
	assign in_ready             = push_ready;

endmodule

// File: src/ppi_queue.sv
// Two-entry queue between the front and the back.
module ppi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ppi_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ppi_pkg::item_t pop_item
);
	import ppi_pkg::*;

	item_t       items_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = items_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Item storage
	always_ff @(posedge clk) begin
		if (push) items_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: src/ppi_back.sv
// Back end: scans appended palette entries, appends new colors, drives results.
module ppi_back #(
	parameter int PALETTE_ENTRIES = ppi_pkg::DEFAULT_PALETTE_ENTRIES,
	parameter int PRESET_ENTRIES  = ppi_pkg::DEFAULT_PRESET_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  ppi_pkg::item_t              pop_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ppi_pkg::INDEX_W-1:0] palette_index,
	output logic [ppi_pkg::COLOR_W-1:0] packed_color,
	output logic                        non_preset_color,
	output logic                        palette_overflow
);
	import ppi_pkg::*;

	localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t             state_q, state_d;
	logic [COLOR_W-1:0] col_q;
	logic [CNT_W-1:0]   nfe_q, nfe_d;
	logic               ovf_q, ovf_d;
	logic [ADDR_W-1:0]  scan_q, scan_d;

	logic [COLOR_W-1:0] mem_q [PALETTE_ENTRIES];
	logic [COLOR_W-1:0] rd_data_q;

	logic               out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [COLOR_W-1:0] out_col_q;
	logic               out_np_q;
	logic               out_ovf_q;

	logic               out_free;
	logic               pop;
	logic [CNT_W-1:0]   nfe_cur;
	logic               ovf_cur;
	logic [COLOR_W-1:0] cur_col;
	logic               finish;
	logic               miss;
	logic [INDEX_W-1:0] fin_idx;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;

	// The output slot is free at pop and only this unit fills it
	assign out_free  = !out_valid_q || out_ready;
	assign pop_ready = (state_q == ST_IDLE) && out_free;
	assign pop       = pop_valid && pop_ready;

	// Start of image reloads the palette before the pixel is handled
	assign nfe_cur = (state_q == ST_IDLE && pop_item.sof) ? CNT_W'(PRESET_ENTRIES) : nfe_q;
	assign ovf_cur = (state_q == ST_IDLE && pop_item.sof) ? 1'b0 : ovf_q;
	assign cur_col = (state_q == ST_IDLE) ? pop_item.color : col_q;

	// Lookup sequencing
	always_comb begin
		state_d = state_q;
		nfe_d   = nfe_q;
		ovf_d   = ovf_q;
		scan_d  = scan_q;
		finish  = 1'b0;
		miss    = 1'b0;
		fin_idx = '0;
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(PRESET_ENTRIES);
		wr_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					nfe_d = nfe_cur;
					ovf_d = ovf_cur;
					if (cur_col == '0 || ovf_cur) begin
						finish = 1'b1;
					end else if (pop_item.preset_hit) begin
						finish  = 1'b1;
						fin_idx = INDEX_W'(pop_item.preset_idx);
					end else if (nfe_cur == CNT_W'(PRESET_ENTRIES)) begin
						miss = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ADDR_W'(PRESET_ENTRIES);
						scan_d  = ADDR_W'(PRESET_ENTRIES);
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (rd_data_q == col_q) begin
					finish  = 1'b1;
					fin_idx = INDEX_W'(scan_q);
					state_d = ST_IDLE;
				end else if (CNT_W'(scan_q) + CNT_W'(1) == nfe_q) begin
					miss    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(CNT_W'(scan_q) + CNT_W'(1));
					scan_d  = rd_addr;
				end
			end
		endcase
		// Not found: append if room, else flag overflow with index 0
		if (miss) begin
			finish = 1'b1;
			if (nfe_cur < CNT_W'(PALETTE_ENTRIES)) begin
				wr_en   = 1'b1;
				fin_idx = INDEX_W'(nfe_cur);
				nfe_d   = nfe_cur + CNT_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	// State, palette bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nfe_q       <= CNT_W'(PRESET_ENTRIES);
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_col_q   <= '0;
			out_np_q    <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			nfe_q   <= nfe_d;
			ovf_q   <= ovf_d;
			scan_q  <= scan_d;
			if (pop) col_q <= pop_item.color;
			if (finish) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= fin_idx;
				out_col_q   <= cur_col;
				out_np_q    <= (fin_idx >= INDEX_W'(PRESET_ENTRIES));
				out_ovf_q   <= ovf_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Appended palette entries, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[nfe_cur[ADDR_W-1:0]] <= cur_col;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign out_valid        = out_valid_q;
	assign palette_index    = out_idx_q;
	assign packed_color     = out_col_q;
	assign non_preset_color = out_np_q;
	assign palette_overflow = out_ovf_q;

endmodule

// File: verif/tb_pixel_palette_indexer.sv
// Self-checking testbench for the pixel palette indexer: directed table, then random images.
module tb_pixel_palette_indexer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAL_DEPTH    = ppi_pkg::DEFAULT_PALETTE_ENTRIES;
	localparam int PRESET_COUNT = ppi_pkg::DEFAULT_PRESET_ENTRIES;
	localparam int NUM_DIR      = 18;
	localparam int RANDOM_ITEMS = 1650;
	localparam int MAX_PRINTS   = 50;

	// CGA colors in BGR555, entry 0 is black
	localparam logic [ppi_pkg::COLOR_W-1:0] BASE_COLORS [16] = '{
		15'h0000, 15'h5400, 15'h02a0, 15'h56a0,
		15'h0015, 15'h5415, 15'h0155, 15'h56b5,
		15'h294a, 15'h7d4a, 15'h2bea, 15'h7fea,
		15'h295f, 15'h7d5f, 15'h2bff, 15'h7fff
	};

	typedef struct packed {
		logic [ppi_pkg::INDEX_W-1:0] idx;
		logic [ppi_pkg::COLOR_W-1:0] col;
		logic                        nps;
		logic                        ovf;
	} pix_res_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       sof;
		logic       typed;
		pix_res_t   want;
	} dir_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [ppi_pkg::CHAN_W-1:0]  red = '0;
	logic [ppi_pkg::CHAN_W-1:0]  green = '0;
	logic [ppi_pkg::CHAN_W-1:0]  blue = '0;
	logic                        start_of_image = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ppi_pkg::INDEX_W-1:0] palette_index;
	logic [ppi_pkg::COLOR_W-1:0] packed_color;
	logic                        non_preset_color;
	logic                        palette_overflow;

	// Typed expectation that travels with the item on the bus
	logic     use_typed = 1'b0;
	pix_res_t typed_res = '0;

	// Predictor state
	logic [ppi_pkg::COLOR_W-1:0] pal_mem [PAL_DEPTH];
	int                          pal_next;
	logic                        pal_ovf;

	pix_res_t expected_q [$];
	int       errors = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	bit       quiet = 1'b0;

	pixel_palette_indexer dut (.*);

	always #10 clk = ~clk;

	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [4:0] chan_to5(input logic [7:0] byte_val);
		logic [3:0] nib;
		nib = byte_val[7:4];
		return (5'(nib) << 1) | 5'(nib >> 3);
	endfunction

	function automatic void reload_palette();
		for (int k = 0; k < PAL_DEPTH; k++)
			pal_mem[k] = (k < PRESET_COUNT) ? BASE_COLORS[k] : '0;
		pal_next = PRESET_COUNT;
		pal_ovf = 1'b0;
	endfunction

	// Expected result for one pixel; updates the palette copy
	function automatic pix_res_t index_pixel(input logic [7:0] r, g, b, input logic sof);
		pix_res_t res;
		logic [ppi_pkg::COLOR_W-1:0] col;
		int idx;
		bit found;
		col = {chan_to5(b), chan_to5(g), chan_to5(r)};
		idx = 0;
		found = 1'b0;
		if (sof)
			reload_palette();
		if (col != '0 && !pal_ovf) begin
			for (int k = 1; k < pal_next && !found; k++) begin
				if (pal_mem[k] == col) begin
					idx = k;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (pal_next < PAL_DEPTH) begin
					idx = pal_next;
					pal_mem[idx] = col;
					pal_next++;
				end else begin
					pal_ovf = 1'b1;
				end
			end
		end
		res.idx = 8'(idx);
		res.col = col;
		res.nps = (idx >= PRESET_COUNT);
		res.ovf = pal_ovf;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTS)
			$display("MISMATCH result %0d %s: got %0h want %0h", n_checked, what, got, want);
		errors++;
	endtask

	function automatic bit idle_roll();
		return !quiet && ($urandom_range(99) < 6);
	endfunction

	// Receiver: random stalls except in the quiet stretch
	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(99) >= 6);

	// Monitor: check results first, then record the accepted item
	always @(posedge clk) begin : monitor
		pix_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no pixel pending", int'(palette_index), 0);
				end else begin
					want = expected_q.pop_front();
					if (palette_index !== want.idx)
						report_mismatch("palette_index", int'(palette_index),
							int'(want.idx));
					if (packed_color !== want.col)
						report_mismatch("packed_color", int'(packed_color),
							int'(want.col));
					if (non_preset_color !== want.nps)
						report_mismatch("non_preset_color", int'(non_preset_color),
							int'(want.nps));
					if (palette_overflow !== want.ovf)
						report_mismatch("palette_overflow", int'(palette_overflow),
							int'(want.ovf));
				end
				n_checked++;
			end
			if (in_valid && in_ready) begin
				want = index_pixel(red, green, blue, start_of_image);
				if (use_typed)
					want = typed_res;
				expected_q.push_back(want);
			end
		end
	end

	task automatic send_pixel(input logic [7:0] r, g, b, input logic sof,
			input logic typed, input pix_res_t want);
		quiet = (n_sent >= 800 && n_sent < 1100);
		if (idle_roll()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_roll());
		end
		in_valid       <= 1'b1;
		red            <= r;
		green          <= g;
		blue           <= b;
		start_of_image <= sof;
		use_typed      <= typed;
		typed_res      <= want;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Pixel from a 12-bit code of three nibbles, low nibbles random
	task automatic send_code(input logic [11:0] code, input logic sof);
		send_pixel({code[3:0], 4'($urandom)}, {code[7:4], 4'($urandom)},
			{code[11:8], 4'($urandom)}, sof, 1'b0, '0);
	endtask

	function automatic logic [11:0] code_of(input logic [ppi_pkg::COLOR_W-1:0] c);
		return {c[14:11], c[9:6], c[4:1]};
	endfunction

	// Short image over a small pool of colors, with presets, black and noise
	task automatic small_image();
		logic [11:0] pool [32];
		int n_pool;
		int len;
		int roll;
		n_pool = $urandom_range(1, 32);
		len = $urandom_range(4, 60);
		for (int k = 0; k < n_pool; k++)
			pool[k] = 12'($urandom);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (i == 0)
				send_code(pool[$urandom_range(n_pool - 1)], 1'b1);
			else if (roll < 8)
				send_code(12'd0, 1'b0);
			else if (roll < 30)
				send_code(code_of(BASE_COLORS[$urandom_range(15)]), 1'b0);
			else if (roll < 35)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
			else
				send_code(pool[$urandom_range(n_pool - 1)], 1'b0);
		end
	endtask

	// Long image of distinct colors that can fill the palette; from pixel 270 on, it revisits old ones
	task automatic fill_image();
		logic [11:0] base;
		logic [11:0] stride;
		int len;
		base = 12'($urandom);
		stride = 12'($urandom) | 12'd1;
		len = $urandom_range(250, 330);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				send_code(base, 1'b1);
			else if ($urandom_range(99) < 5)
				send_code(12'd0, 1'b0);
			else if (i >= 270)
				send_code(base + 12'($urandom_range(200)) * stride, 1'b0);
			else
				send_code(base + 12'(i) * stride, 1'b0);
		end
	endtask

	initial begin : stimulus
		dir_row_t rows [NUM_DIR];
		int img;
		rows = '{
			'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd0,  15'h0000, 1'b0, 1'b0}},
			'{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd15, 15'h7fff, 1'b0, 1'b0}},
			'{8'h0f, 8'h0f, 8'h0f, 1'b0, 1'b1, '{8'd0,  15'h0000, 1'b0, 1'b0}},
			'{8'hf0, 8'hf0, 8'hf0, 1'b0, 1'b1, '{8'd15, 15'h7fff, 1'b0, 1'b0}},
			'{8'h80, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd16, 15'h0011, 1'b1, 1'b0}},
			'{8'h8f, 8'h0a, 8'h03, 1'b0, 1'b1, '{8'd16, 15'h0011, 1'b1, 1'b0}},
			'{8'h00, 8'h80, 8'h00, 1'b0, 1'b1, '{8'd17, 15'h0220, 1'b1, 1'b0}},
			'{8'h00, 8'h00, 8'h80, 1'b0, 1'b1, '{8'd18, 15'h4400, 1'b1, 1'b0}},
			'{8'ha0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd4,  15'h0015, 1'b0, 1'b0}},
			'{8'h50, 8'h50, 8'h50, 1'b0, 1'b1, '{8'd8,  15'h294a, 1'b0, 1'b0}},
			'{8'h50, 8'ha0, 8'ha0, 1'b0, 1'b0, '0},
			'{8'h7f, 8'h7f, 8'h7f, 1'b0, 1'b0, '0},
			'{8'h80, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd16, 15'h0011, 1'b1, 1'b0}},
			'{8'h00, 8'h80, 8'h00, 1'b0, 1'b1, '{8'd17, 15'h0220, 1'b1, 1'b0}},
			'{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd0,  15'h0000, 1'b0, 1'b0}},
			'{8'h55, 8'haa, 8'h55, 1'b0, 1'b0, '0},
			'{8'h10, 8'h20, 8'h30, 1'b0, 1'b0, '0},
			'{8'hff, 8'h00, 8'hff, 1'b1, 1'b1, '{8'd16, 15'h7c1f, 1'b1, 1'b0}}
		};
		reload_palette();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < NUM_DIR; i++)
			send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].sof, rows[i].typed, rows[i].want);

		// Random images, one palette-filling image in six
		img = 0;
		while (n_sent < NUM_DIR + RANDOM_ITEMS) begin
			if (img % 6 == 2)
				fill_image();
			else
				small_image();
			img++;
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		// Drain, then allow for the longest lookup
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
